// ----- rtl/ffa_pkg.sv -----
package ffa_pkg;

    // Default heap geometry
    localparam int DEF_HEAP_BYTES   = 4096;
    localparam int DEF_HEADER_BYTES = 17;
    localparam int DEF_MIN_CAPACITY = 24;

    // Fixed port widths
    localparam int REQ_SIZE_W = 13;
    localparam int ADDR_W     = 12;
    localparam int STATUS_W   = 2;

    // Request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_ZERO_SIZE = 2'd2
    } status_t;

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RD    = 7'b0000100,
        S_CHK   = 7'b0001000,
        S_SPLIT = 7'b0010000,
        S_MRD   = 7'b0100000,
        S_MCHK  = 7'b1000000
    } state_t;

endpackage

// ----- rtl/ffa_hdr_ram.sv -----
module ffa_hdr_ram
    import ffa_pkg::*;
#(
    parameter int DEPTH = DEF_HEAP_BYTES,
    parameter int AW    = $clog2(DEF_HEAP_BYTES),
    parameter int DW    = $clog2(DEF_HEAP_BYTES) + 1
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/first_fit_block_allocator.sv -----
// Channel   | Direction | Handshake                | Payload
// ----------+-----------+--------------------------+---------------------------------
// request   | in        | start && !busy           | req_type, req_size, block_address
// result    | out       | done (one cycle strobe)  | result_address, status
//
// Walk: the sequencer visits one block header at a time, in S_RD (address) and then S_CHK
//   (check), through the single read port of the header RAM. Allocate reads B headers,
//   plus the S_SPLIT state on a split. Free reads B headers, then M headers past the target
//   (the used one that ends the merge included). Zero size and null free answer at once.
// Reset: one cycle after reset writes the full-heap free header at offset 0, busy high.
// Stalls: busy stays high while a walk is in progress; the result strobe cannot be held off.
module first_fit_block_allocator
    import ffa_pkg::*;
#(
    parameter int HEAP_BYTES   = DEF_HEAP_BYTES,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES,
    parameter int MIN_CAPACITY = DEF_MIN_CAPACITY
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  req_type,
    input  logic [REQ_SIZE_W-1:0] req_size,
    input  logic [ADDR_W-1:0]     block_address,
    output logic                  done,
    output logic [ADDR_W-1:0]     result_address,
    output logic [STATUS_W-1:0]   status
);

    // Header offsets and capacities are below HEAP_BYTES; arithmetic runs wider
    localparam int AW = $clog2(HEAP_BYTES);
    localparam int DW = AW + 1;
    localparam int WW = ((AW > REQ_SIZE_W) ? AW : REQ_SIZE_W) + 2;

    localparam logic [WW-1:0] HEAP_W   = WW'(HEAP_BYTES);
    localparam logic [WW-1:0] HDR_W    = WW'(HEADER_BYTES);
    localparam logic [WW-1:0] MINCAP_W = WW'(MIN_CAPACITY);
    localparam logic [AW-1:0] INIT_CAP = AW'(HEAP_BYTES - HEADER_BYTES);

    state_t              state_reg, state_next;
    logic                type_reg, type_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [WW-1:0]       q_reg, q_next;          // rounded request
    logic [WW-1:0]       qh_reg, qh_next;        // request plus header
    logic [WW-1:0]       qhm_reg, qhm_next;      // smallest capacity that splits
    logic [AW-1:0]       h_reg, h_next;          // header being visited
    logic [AW-1:0]       n_reg, n_next;          // following header during merge
    logic [AW-1:0]       acc_reg, acc_next;      // capacity being built up
    logic                done_reg, done_next;
    logic [ADDR_W-1:0]   res_reg, res_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    // Header RAM port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    // Fields of the header just read, and the walk arithmetic
    logic          hdr_free;
    logic [WW-1:0] hdr_cap;
    logic [WW-1:0] contents;   // contents address of the visited block
    logic [WW-1:0] next_blk;   // header that follows the block just read
    logic [WW-1:0] acc_sum;    // merged capacity
    logic [WW-1:0] size_w;

    ffa_hdr_ram #(
        .DEPTH (HEAP_BYTES),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign hdr_free = ram_rdata[AW];
    assign hdr_cap  = WW'(ram_rdata[AW-1:0]);
    assign size_w   = WW'(req_size);

    // One shared walk adder: the chain pointer during the search, the next
    // neighbor during a merge.
    always_comb
    begin
        contents = WW'(h_reg) + HDR_W;
        if (state_reg == S_MCHK)
        begin
            next_blk = WW'(n_reg) + HDR_W + hdr_cap;
        end
        else
        begin
            next_blk = contents + hdr_cap;
        end
        acc_sum = WW'(acc_reg) + hdr_cap + HDR_W;
    end

    always_comb
    begin
        state_next  = state_reg;
        type_next   = type_reg;
        addr_next   = addr_reg;
        q_next      = q_reg;
        qh_next     = qh_reg;
        qhm_next    = qhm_reg;
        h_next      = h_reg;
        n_next      = n_reg;
        acc_next    = acc_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = h_reg;
        ram_wdata   = {1'b0, acc_reg};
        ram_raddr   = h_reg;

        case (state_reg)
            S_INIT:
            begin
                // Lay down the single free block that spans the heap
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = {1'b1, INIT_CAP};
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (start)
                begin
                    type_next = req_type;
                    addr_next = block_address;
                    h_next    = '0;
                    res_next  = '0;
                    if (req_type == REQ_ALLOC)
                    begin
                        if (req_size == '0)
                        begin
                            // Zero size: answer at once, touch nothing
                            done_next   = 1'b1;
                            status_next = ST_ZERO_SIZE;
                        end
                        else
                        begin
                            q_next     = (size_w < MINCAP_W) ? MINCAP_W : size_w;
                            qh_next    = ((size_w < MINCAP_W) ? MINCAP_W : size_w) + HDR_W;
                            qhm_next   = ((size_w < MINCAP_W) ? MINCAP_W : size_w) + HDR_W
                                         + MINCAP_W;
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        status_next = ST_OK;
                        if (block_address == '0)
                        begin
                            // Null free: nothing to do
                            done_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                end
            end

            S_RD:
            begin
                ram_raddr  = h_reg;
                state_next = S_CHK;
            end

            S_CHK:
            begin
                if (type_reg == REQ_ALLOC)
                begin
                    if (hdr_free && (hdr_cap >= q_reg))
                    begin
                        res_next    = contents[ADDR_W-1:0];
                        status_next = ST_OK;
                        if (qhm_reg <= hdr_cap)
                        begin
                            // Split: drop the remainder header first
                            ram_we     = 1'b1;
                            ram_waddr  = AW'(WW'(h_reg) + qh_reg);
                            ram_wdata  = {1'b1, AW'(hdr_cap - qh_reg)};
                            acc_next   = AW'(q_reg);
                            state_next = S_SPLIT;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = h_reg;
                            ram_wdata  = {1'b0, AW'(hdr_cap)};
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else if (next_blk >= HEAP_W)
                    begin
                        res_next    = '0;
                        status_next = ST_NO_FIT;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        h_next     = AW'(next_blk);
                        state_next = S_RD;
                    end
                end
                else
                begin
                    if (contents == WW'(addr_reg))
                    begin
                        acc_next = AW'(hdr_cap);
                        if (next_blk >= HEAP_W)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = h_reg;
                            ram_wdata  = {1'b1, AW'(hdr_cap)};
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            n_next     = AW'(next_blk);
                            state_next = S_MRD;
                        end
                    end
                    else if ((contents > WW'(addr_reg)) || (next_blk >= HEAP_W))
                    begin
                        // Address names no block: ignore
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        h_next     = AW'(next_blk);
                        state_next = S_RD;
                    end
                end
            end

            S_SPLIT:
            begin
                // Shrink the taken block to the request and mark it used
                ram_we     = 1'b1;
                ram_waddr  = h_reg;
                ram_wdata  = {1'b0, acc_reg};
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_MRD:
            begin
                ram_raddr  = n_reg;
                state_next = S_MCHK;
            end

            S_MCHK:
            begin
                if (hdr_free)
                begin
                    acc_next = AW'(acc_sum);
                    if (next_blk >= HEAP_W)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = h_reg;
                        ram_wdata  = {1'b1, AW'(acc_sum)};
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        n_next     = AW'(next_blk);
                        state_next = S_MRD;
                    end
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = h_reg;
                    ram_wdata  = {1'b1, acc_reg};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        type_reg   <= type_next;
        addr_reg   <= addr_next;
        q_reg      <= q_next;
        qh_reg     <= qh_next;
        qhm_reg    <= qhm_next;
        h_reg      <= h_next;
        n_reg      <= n_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
        status_reg <= status_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign result_address = res_reg;
    assign status         = status_reg;

endmodule

// ----- rtl/ffa_checker.sv -----
module ffa_checker
    import ffa_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic [ADDR_W-1:0]     result_address,
    input logic [STATUS_W-1:0]   status
);

    // An accepted transaction either answers at once or holds busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction neither answered nor went busy");

    // A result is shown only once the sequencer is back at rest
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Failed allocations carry a null address
    a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (result_address == '0))
        else $error("failed request returned a nonzero address");

    // A result always follows an accepted transaction or a busy stretch
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result strobe without a transaction");

endmodule

bind first_fit_block_allocator ffa_checker u_ffa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .result_address (result_address),
    .status         (status)
);
